// ----- src/b64le_pkg.sv -----
// ----------------------------------------------------------------------------
// b64le_pkg: shared types and constants of the line-wrapped base64 encoder
// Holds the character codes, the burst type passed from the group stage to
// the character emitter, and the base64 symbol lookup.
// ----------------------------------------------------------------------------
package b64le_pkg;

	localparam int unsigned BURST_MAX = 6;
	localparam int unsigned CNT_W     = 3;

	localparam logic [7:0] LINE_FEED = 8'h0A;
	localparam logic [7:0] PAD_CHAR  = 8'h3D;

	// Characters caused by one input item, in emit order
	typedef struct packed {
		logic                            load;
		logic [BURST_MAX-1:0][7:0]       chars;
		logic [CNT_W-1:0]                count;
		logic                            msg_end;
	} burst_t;

	// Map a six-bit value onto the standard base64 alphabet
	function automatic logic [7:0] sym(input logic [5:0] six);
		logic [7:0] v;
		v = {2'b00, six};
		if (six < 6'd26) begin
			sym = 8'h41 + v;
		end else if (six < 6'd52) begin
			sym = 8'h61 + (v - 8'd26);
		end else if (six < 6'd62) begin
			sym = 8'h30 + (v - 8'd52);
		end else if (six == 6'd62) begin
			sym = 8'h2B;
		end else begin
			sym = 8'h2F;
		end
	endfunction

endpackage

// ----- src/b64le_in_if.sv -----
// ----------------------------------------------------------------------------
// b64le_in_if: byte input channel
// Valid/ready channel carrying one message byte and its end flag.
// ----------------------------------------------------------------------------
interface b64le_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- src/b64le_out_if.sv -----
// ----------------------------------------------------------------------------
// b64le_out_if: character output channel
// Valid/ready channel carrying one output character and its markers.
// ----------------------------------------------------------------------------
interface b64le_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       run_last;
	logic       message_end;

	modport source (output valid, output out_char, output run_last, output message_end,
		input ready);
	modport sink (input valid, input out_char, input run_last, input message_end,
		output ready);
endinterface

// ----- src/b64le_group.sv -----
// ----------------------------------------------------------------------------
// b64le_group: group assembly and character generation
// Holds the open three-byte group and the line position, and turns each
// accepted item into the burst of characters it causes.
// ----------------------------------------------------------------------------
module b64le_group
	import b64le_pkg::*;
#(
	parameter int unsigned GROUPS_PER_LINE = 18
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output burst_t     burst
);

	localparam int unsigned GW = $clog2(GROUPS_PER_LINE + 1);
	localparam logic [GW-1:0] GROUP_WRAP = GW'(GROUPS_PER_LINE - 1);

	logic [7:0]    held_first_q;
	logic [7:0]    held_second_q;
	logic [1:0]    phase_q;
	logic [GW-1:0] groups_q;

	logic [7:0]    first_d;
	logic [7:0]    second_d;
	logic [1:0]    phase_d;
	logic [GW-1:0] groups_d;

	// Build the character burst and the next state
	always_comb begin
		logic [7:0] a;
		logic [7:0] b;
		logic [CNT_W-1:0] n;
		burst.chars   = '0;
		burst.msg_end = last_byte;
		first_d       = held_first_q;
		second_d      = held_second_q;
		phase_d       = phase_q;
		groups_d      = groups_q;
		n             = '0;
		a             = held_first_q;
		b             = held_second_q;

		if (phase_q == 2'd2) begin
			burst.chars[0] = sym(a[7:2]);
			burst.chars[1] = sym({a[1:0], b[7:4]});
			burst.chars[2] = sym({b[3:0], data_byte[7:6]});
			burst.chars[3] = sym(data_byte[5:0]);
			n       = CNT_W'(4);
			phase_d = 2'd0;
			if (groups_q == GROUP_WRAP) begin
				burst.chars[4] = LINE_FEED;
				n        = CNT_W'(5);
				groups_d = '0;
			end else begin
				groups_d = groups_q + GW'(1);
			end
		end else if (phase_q == 2'd1) begin
			second_d = data_byte;
			phase_d  = 2'd2;
		end else begin
			first_d = data_byte;
			phase_d = 2'd1;
		end

		if (last_byte) begin
			// Pad a leftover of one or two bytes; the full-group case left n above zero
			if (phase_q == 2'd1) begin
				burst.chars[0] = sym(a[7:2]);
				burst.chars[1] = sym({a[1:0], data_byte[7:4]});
				burst.chars[2] = sym({data_byte[3:0], 2'b00});
				burst.chars[3] = PAD_CHAR;
				n = CNT_W'(4);
			end else if (phase_q == 2'd0) begin
				burst.chars[0] = sym(data_byte[7:2]);
				burst.chars[1] = sym({data_byte[1:0], 4'b0000});
				burst.chars[2] = PAD_CHAR;
				burst.chars[3] = PAD_CHAR;
				n = CNT_W'(4);
			end
			burst.chars[n] = LINE_FEED;
			n        = n + CNT_W'(1);
			first_d  = '0;
			second_d = '0;
			phase_d  = '0;
			groups_d = '0;
		end

		burst.count = n;
		burst.load  = accept && (n != '0);
	end

	// Hold the open group and line position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_first_q  <= '0;
			held_second_q <= '0;
			phase_q       <= '0;
			groups_q      <= '0;
		end else if (accept) begin
			held_first_q  <= first_d;
			held_second_q <= second_d;
			phase_q       <= phase_d;
			groups_q      <= groups_d;
		end
	end

endmodule

// ----- src/b64le_emit.sv -----
// ----------------------------------------------------------------------------
// b64le_emit: character emitter
// Registers a burst of characters and sends them out one per cycle while the
// receiver is ready, marking the burst's last character and the message end.
// ----------------------------------------------------------------------------
module b64le_emit
	import b64le_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  burst_t              burst,
	output logic                room,
	b64le_out_if.source         char_out
);

	logic [BURST_MAX-1:0][7:0] chars_q;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          idx_q;
	logic                      end_q;
	logic                      busy_q;
	logic                      at_last;
	logic                      fire;

	assign at_last = (idx_q == count_q - CNT_W'(1));
	assign fire    = busy_q && char_out.ready;
	assign room    = !busy_q || (fire && at_last);

	assign char_out.valid       = busy_q;
	assign char_out.out_char    = chars_q[idx_q];
	assign char_out.run_last    = at_last;
	assign char_out.message_end = at_last && end_q;

	// Load a new burst or advance through the current one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (burst.load) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (fire) begin
			busy_q <= !at_last;
			idx_q  <= idx_q + CNT_W'(1);
		end
	end

	// Hold the burst payload
	always_ff @(posedge clk) begin
		if (burst.load) begin
			chars_q <= burst.chars;
			count_q <= burst.count;
			end_q   <= burst.msg_end;
		end
	end

endmodule

// ----- src/base64_line_wrapped_encoder.sv -----
// Timing: the first character of an item is valid in the cycle after its acceptance.
// Throughput: one character per cycle while the receiver is ready, set by the
// single character output port, with no new item taken mid-burst.
// Items causing no characters are taken in the next cycle the emitter has room.
// Reset: arst_n clears the open group, the line position and the emitter.
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder: base64 encoder with line wrapping
// Encodes a byte stream into base64 with a line feed after every
// GROUPS_PER_LINE groups and a padded tail and final line feed per message.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder
	import b64le_pkg::*;
#(
	parameter int unsigned GROUPS_PER_LINE = 18
) (
	input  logic        clk,
	input  logic        arst_n,
	b64le_in_if.sink    byte_in,
	b64le_out_if.source char_out
);

	burst_t burst;
	logic   room;
	logic   accept;

	assign byte_in.ready = room;
	assign accept        = byte_in.valid && room;

	// Assemble groups and generate characters
	b64le_group #(
		.GROUPS_PER_LINE(GROUPS_PER_LINE)
	) u_group (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (byte_in.data_byte),
		.last_byte (byte_in.last_byte),
		.burst     (burst)
	);

	// Send characters one per cycle while the receiver is ready
	b64le_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.burst    (burst),
		.room     (room),
		.char_out (char_out)
	);

endmodule

// ----- dv/base64_line_wrapped_encoder_test.sv -----
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder_test: self-checking bench of the base64 encoder
// Drives messages of bytes into the encoder and checks every output character
// and its run and message markers against literals or an in-bench encoder.
// A short directed list covers padding, byte extremes and full groups.
// Random messages follow, some long enough to wrap lines or end exactly on a
// line boundary. They run under phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder_test;
	import b64le_pkg::*;

	localparam int unsigned GROUPS_PER_LINE = 18;
	localparam int          DIRECTED_N      = 20;
	localparam int          PHASE_ITEMS     = 40;

	localparam logic [0:63][7:0] B64_SYMBOLS =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	// One output character with its markers
	typedef struct packed {
		logic [7:0] ch;
		logic       run_last;
		logic       msg_end;
	} char_rec_t;

	// One directed item; literal characters are used when use_model is low
	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        use_model;
		logic [2:0]  want_n;
		logic [47:0] want;
	} stim_row_t;

	localparam stim_row_t DIRECTED [DIRECTED_N] = '{
		'{8'h00, 1'b1, 1'b0, 3'd5, "AA==\n"},
		'{8'hFF, 1'b1, 1'b0, 3'd5, "/w==\n"},
		'{8'h00, 1'b0, 1'b0, 3'd0, 48'd0},
		'{8'h00, 1'b1, 1'b0, 3'd5, "AAA=\n"},
		'{8'hFF, 1'b0, 1'b0, 3'd0, 48'd0},
		'{8'hFF, 1'b1, 1'b0, 3'd5, "//8=\n"},
		'{8'h00, 1'b0, 1'b0, 3'd0, 48'd0},
		'{8'h00, 1'b0, 1'b0, 3'd0, 48'd0},
		'{8'h00, 1'b1, 1'b0, 3'd5, "AAAA\n"},
		'{8'hFF, 1'b0, 1'b0, 3'd0, 48'd0},
		'{8'hFF, 1'b0, 1'b0, 3'd0, 48'd0},
		'{8'hFF, 1'b1, 1'b0, 3'd5, "////\n"},
		'{8'h4D, 1'b0, 1'b0, 3'd0, 48'd0},
		'{8'h61, 1'b0, 1'b0, 3'd0, 48'd0},
		'{8'h6E, 1'b0, 1'b0, 3'd4, "TWFu"},
		'{8'hA5, 1'b1, 1'b1, 3'd0, 48'd0},
		'{8'hFC, 1'b0, 1'b1, 3'd0, 48'd0},
		'{8'h03, 1'b0, 1'b1, 3'd0, 48'd0},
		'{8'hC0, 1'b0, 1'b1, 3'd0, 48'd0},
		'{8'h3F, 1'b1, 1'b1, 3'd0, 48'd0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;

	b64le_in_if  byte_in ();
	b64le_out_if char_out ();

	assign char_out.ready = sink_ready;

	base64_line_wrapped_encoder #(
		.GROUPS_PER_LINE(GROUPS_PER_LINE)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_in (byte_in),
		.char_out(char_out)
	);

	always #6 clk = ~clk;

	// Encoder state mirrored by the bench
	logic [7:0] grp_first;
	logic [7:0] grp_second;
	logic [1:0] grp_fill;
	logic [4:0] line_groups;

	logic [7:0] run_chars[$];
	char_rec_t  expected_chars[$];
	char_rec_t  exp_rec;
	char_rec_t  got_rec;

	int gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int msgs_sent = 0;
	int bytes_sent = 0;
	int chars_checked = 0;
	int line_wraps = 0;
	int boundary_ends = 0;

	// Compute the characters one byte causes and advance the mirrored state
	task automatic encode_byte(input logic [7:0] b, input logic is_last);
		logic wrapped;
		wrapped = 1'b0;
		run_chars.delete();
		if (grp_fill == 2'd2) begin
			run_chars.push_back(B64_SYMBOLS[grp_first[7:2]]);
			run_chars.push_back(B64_SYMBOLS[{grp_first[1:0], grp_second[7:4]}]);
			run_chars.push_back(B64_SYMBOLS[{grp_second[3:0], b[7:6]}]);
			run_chars.push_back(B64_SYMBOLS[b[5:0]]);
			grp_fill = 2'd0;
			line_groups = line_groups + 5'd1;
			if (line_groups >= GROUPS_PER_LINE) begin
				run_chars.push_back(LINE_FEED);
				line_groups = 5'd0;
				wrapped = 1'b1;
				line_wraps++;
			end
		end else if (grp_fill == 2'd1) begin
			grp_second = b;
			grp_fill = 2'd2;
		end else begin
			grp_first = b;
			grp_fill = 2'd1;
		end
		// Close the message: pad the leftover, then the final line feed
		if (is_last) begin
			if (grp_fill == 2'd2) begin
				run_chars.push_back(B64_SYMBOLS[grp_first[7:2]]);
				run_chars.push_back(B64_SYMBOLS[{grp_first[1:0], grp_second[7:4]}]);
				run_chars.push_back(B64_SYMBOLS[{grp_second[3:0], 2'b00}]);
				run_chars.push_back(PAD_CHAR);
			end else if (grp_fill == 2'd1) begin
				run_chars.push_back(B64_SYMBOLS[grp_first[7:2]]);
				run_chars.push_back(B64_SYMBOLS[{grp_first[1:0], 4'b0000}]);
				run_chars.push_back(PAD_CHAR);
				run_chars.push_back(PAD_CHAR);
			end
			run_chars.push_back(LINE_FEED);
			if (wrapped)
				boundary_ends++;
			grp_first = 8'd0;
			grp_second = 8'd0;
			grp_fill = 2'd0;
			line_groups = 5'd0;
		end
	endtask

	// Offer one item, wait for its acceptance and queue its characters
	task automatic send_byte(input logic [7:0] b, input logic is_last,
		input logic use_model, input logic [2:0] want_n, input logic [47:0] want);
		char_rec_t rec;
		int        i;
		int        n;
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			byte_in.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		byte_in.valid <= 1'b1;
		byte_in.data_byte <= b;
		byte_in.last_byte <= is_last;
		do @(posedge clk); while (!byte_in.ready);
		bytes_sent++;
		if (is_last)
			msgs_sent++;
		encode_byte(b, is_last);
		n = use_model ? run_chars.size() : int'(want_n);
		for (i = 0; i < n; i++) begin
			rec.ch = use_model ? run_chars[i] : want[8*(n-1-i) +: 8];
			rec.run_last = (i == n - 1);
			rec.msg_end = is_last && (i == n - 1);
			expected_chars.push_back(rec);
		end
	endtask

	// Hold off the sender until every queued character has come out
	task automatic drain_output();
		byte_in.valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
	endtask

	// Check each accepted character and stall the output at random
	always @(posedge clk) begin
		if (arst_n && char_out.valid && sink_ready) begin
			got_rec = '{char_out.out_char, char_out.run_last, char_out.message_end};
			if (expected_chars.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected character: expected none, actual char %h run_last %b msg_end %b",
					$time, got_rec.ch, got_rec.run_last, got_rec.msg_end);
			end else begin
				exp_rec = expected_chars.pop_front();
				chars_checked++;
				if (got_rec.ch !== exp_rec.ch || got_rec.run_last !== exp_rec.run_last ||
					got_rec.msg_end !== exp_rec.msg_end) begin
					mismatches++;
					$display("%0t: mismatch: expected char %h run_last %b msg_end %b, actual char %h run_last %b msg_end %b",
						$time, exp_rec.ch, exp_rec.run_last, exp_rec.msg_end,
						got_rec.ch, got_rec.run_last, got_rec.msg_end);
				end
			end
		end
		sink_ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// Stop a hung run
	initial begin
		#2400000;
		$display("base64_line_wrapped_encoder test failed");
		$finish;
	end

	initial begin
		int ph;
		int r;
		int i;
		int msg_len;
		int phase_items;
		bit first_msg;
		byte_in.valid = 1'b0;
		byte_in.data_byte = 8'd0;
		byte_in.last_byte = 1'b0;
		grp_first = 8'd0;
		grp_second = 8'd0;
		grp_fill = 2'd0;
		line_groups = 5'd0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: padding of one and two bytes, extremes, full groups
		for (r = 0; r < DIRECTED_N; r++)
			send_byte(DIRECTED[r].data, DIRECTED[r].last, DIRECTED[r].use_model,
				DIRECTED[r].want_n, DIRECTED[r].want);
		drain_output();

		// Random messages under each idling pattern
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 86; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 86; end
				default: begin gap_pct = 33; stall_pct = 33; end
			endcase
			phase_items = 0;
			first_msg = 1'b1;
			while (phase_items < PHASE_ITEMS) begin
				// Mostly short messages; some near one line, phase 0's first exactly one
				if (first_msg && ph == 0)
					msg_len = 3 * GROUPS_PER_LINE;
				else if ($urandom_range(4) == 0)
					msg_len = $urandom_range(3 * GROUPS_PER_LINE + 3, 3 * GROUPS_PER_LINE - 2);
				else
					msg_len = $urandom_range(12, 1);
				first_msg = 1'b0;
				for (i = 0; i < msg_len; i++)
					send_byte(8'($urandom_range(255)), i == msg_len - 1, 1'b1, 3'd0, 48'd0);
				phase_items += msg_len;
			end
			drain_output();
		end

		// Let any stray characters show up
		repeat (20) @(posedge clk);
		$display("Covered %0d messages, %0d bytes, %0d characters checked.",
			msgs_sent, bytes_sent, chars_checked);
		$display("Saw %0d line wraps, %0d messages ending on a line boundary.",
			line_wraps, boundary_ends);
		if (mismatches == 0)
			$display("base64_line_wrapped_encoder test passed");
		else
			$display("base64_line_wrapped_encoder test failed");
		$finish;
	end

endmodule
